/* design/rrgp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rrgp_pkg;
  localparam int MAX_VERTICES = 256;
  localparam int MAX_DEGREE = 9;

  localparam logic [3:0] ST_ADDED = 4'd0;
  localparam logic [3:0] ST_SAME = 4'd1;
  localparam logic [3:0] ST_EXISTS = 4'd2;
  localparam logic [3:0] ST_FINAL_OK = 4'd3;
  localparam logic [3:0] ST_FINAL_FAIL = 4'd4;
  localparam logic [3:0] ST_BAD_PICK = 4'd5;
  localparam logic [3:0] ST_IDLE_RUN = 4'd6;
  localparam logic [3:0] ST_STARTED = 4'd7;
  localparam logic [3:0] ST_BAD_CFG = 4'd8;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_DEGREE = 1'b1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_PAIR = 1'b1;
endpackage
`default_nettype wire

/* design/rrgp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module rrgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/random_regular_graph_pairing.sv */
`timescale 1ns / 1ps
// A start fills the list and clears the adjacency rows together, one entry each per cycle.
// A pair finds its vertex numbers a and b by subtracting K once per cycle; an accepted pair
// then shifts list entries through the single port of the list memory, and after the last
// add the closing edge is checked and written as well.
// One request is in work at a time. Reset (rst, synchronous): running and rem cleared.
`default_nettype none
module random_regular_graph_pairing #(
  parameter int MAX_VERTICES = rrgp_pkg::MAX_VERTICES,
  parameter int MAX_DEGREE = rrgp_pkg::MAX_DEGREE
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [11:0] first_pick,
  input  wire logic [11:0] second_pick,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       status,
  output logic [7:0]       vertex_a,
  output logic [7:0]       vertex_b,
  output logic [11:0]      remaining,
  output logic             last
);
  localparam int CAP = MAX_VERTICES * MAX_DEGREE;
  localparam int PW = $clog2(CAP);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int KW = $clog2(MAX_DEGREE + 1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_FILL   = 14'b00000000000010,
    S_RD1    = 14'b00000000000100,
    S_DIV1   = 14'b00000000001000,
    S_RD2    = 14'b00000000010000,
    S_DIV2   = 14'b00000000100000,
    S_ADJ    = 14'b00000001000000,
    S_CHK    = 14'b00000010000000,
    S_SETB   = 14'b00000100000000,
    S_SHRD   = 14'b00001000000000,
    S_SHWR   = 14'b00010000000000,
    S_OUT    = 14'b00100000000000,
    S_CLOSE  = 14'b01000000000000,
    S_WAIT   = 14'b10000000000000
  } state_t;

  state_t state;
  logic [8:0] vertex_count;
  logic [3:0] degree;
  logic [KW-1:0] run_k;
  logic running;
  logic [11:0] rem;
  logic [11:0] p1, p2;
  logic [PW-1:0] cnt;
  logic [VW:0] rowcnt, row_end;
  logic [11:0] pt;
  logic [11:0] divq;
  logic [11:0] divr;
  logic [VW-1:0] va, vb;
  logic closing, second_rm;

  // list memory
  logic          l_we;
  logic [PW-1:0] l_waddr, l_raddr;
  logic [11:0]   l_wdata, l_rdata;
  rrgp_ram #(.WIDTH(12), .DEPTH(CAP)) u_list (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata));

  // adjacency rows memory
  logic                    a_we;
  logic [VW-1:0]           a_waddr, a_raddr;
  logic [MAX_VERTICES-1:0] a_wdata, a_rdata;
  rrgp_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata));

  logic [MAX_VERTICES-1:0] row_a;

  logic cfg_bad;
  assign cfg_bad = (vertex_count < 9'd2) || ({23'd0, vertex_count} > MAX_VERTICES)
                   || vertex_count[0] || (degree < 4'd3) || ({28'd0, degree} > MAX_DEGREE);

  logic [11:0] nk;
  assign nk = 12'(vertex_count) * 12'(degree);

  assign in_ready = (state == S_IDLE) && !out_valid;

  // The closing result must wait until the add result before it has been taken.
  logic hold_close;
  assign hold_close = closing && out_valid && !out_ready;

  // Vertex of a point: quotient by subtraction, at most one step per vertex.
  logic [VW-1:0] vq_sat;
  assign vq_sat = (divq >= 12'(MAX_VERTICES)) ? VW'(MAX_VERTICES - 1) : divq[VW-1:0];

  always_comb begin
    l_we = 1'b0; l_waddr = cnt; l_wdata = 12'(cnt); l_raddr = cnt;
    a_we = 1'b0; a_waddr = rowcnt[VW-1:0]; a_wdata = '0; a_raddr = va;
    case (state)
      S_FILL: begin
        l_we = (12'(cnt) < rem);
        a_we = (rowcnt < row_end);
      end
      S_IDLE, S_RD1: l_raddr = p1[PW-1:0];
      S_RD2, S_DIV1: l_raddr = p2[PW-1:0];
      S_ADJ: a_raddr = va;
      S_SETB: begin
        a_we = !hold_close; a_waddr = va; a_wdata = row_a | (MAX_VERTICES'(1) << vb);
      end
      S_SHRD: l_raddr = PW'(cnt + 1'b1);
      S_SHWR: begin
        l_we = 1'b1; l_waddr = cnt; l_wdata = l_rdata;
      end
      default: ;
    endcase
  end

  // A new result is loaded in these cases.
  logic res_load;
  always_comb begin
    res_load = 1'b0;
    case (state)
      S_IDLE: res_load = in_valid && in_ready &&
                         ((operation == rrgp_pkg::OP_START) ? cfg_bad :
                          (!running || first_pick >= rem || second_pick >= rem));
      S_FILL: res_load = !(12'(cnt) < rem) && !(rowcnt < row_end);
      S_CHK: res_load = !hold_close && (pt != 12'd1) && (va == vb || a_rdata[vb]);
      S_SETB: res_load = !hold_close && (pt != 12'd0) && closing;
      S_OUT: res_load = !out_valid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vertex_count <= 9'd4;
      degree <= 4'd3;
      run_k <= KW'(3);
      running <= 1'b0;
      rem <= '0;
      out_valid <= 1'b0;
      closing <= 1'b0;
      second_rm <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rrgp_pkg::REG_VERTEX_COUNT) vertex_count <= cfg_data;
        else degree <= cfg_data[3:0];
      end
      if (res_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            p1 <= first_pick; p2 <= second_pick;
            vertex_a <= '0; vertex_b <= '0;
            if (operation == rrgp_pkg::OP_START) begin
              if (cfg_bad) begin
                running <= 1'b0; rem <= '0;
                status <= rrgp_pkg::ST_BAD_CFG; remaining <= '0; last <= 1'b1;
              end else begin
                run_k <= KW'(degree); rem <= nk;
                cnt <= '0; rowcnt <= '0; row_end <= (VW+1)'(MAX_VERTICES);
                state <= S_FILL;
              end
            end else if (!running) begin
              status <= rrgp_pkg::ST_IDLE_RUN; remaining <= rem; last <= 1'b1;
            end else if (first_pick >= rem || second_pick >= rem) begin
              status <= rrgp_pkg::ST_BAD_PICK; remaining <= rem; last <= 1'b1;
            end else begin
              closing <= 1'b0;
              state <= S_RD1;
            end
          end
        end
        S_FILL: begin
          cnt <= (12'(cnt) < rem) ? PW'(cnt + 1'b1) : cnt;
          rowcnt <= (rowcnt < row_end) ? rowcnt + 1'b1 : rowcnt;
          if (!(12'(cnt) < rem) && !(rowcnt < row_end)) begin
            running <= 1'b1;
            status <= rrgp_pkg::ST_STARTED; remaining <= rem; last <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RD1: begin
          // read of first point in flight
          state <= S_DIV1;
          divq <= '0;
        end
        S_DIV1: begin
          // first cycle captures point, then subtracts K per cycle
          if (divq == '0 && !second_rm) begin
            divr <= l_rdata; second_rm <= 1'b1; pt <= 12'hFFF;
          end else if (divr >= 12'(run_k)) begin
            divr <= divr - 12'(run_k); divq <= divq + 1'b1;
          end else begin
            va <= vq_sat; divq <= '0; second_rm <= 1'b0;
            state <= S_RD2;
          end
        end
        S_RD2: state <= S_DIV2;
        S_DIV2: begin
          if (divq == '0 && !second_rm) begin
            divr <= l_rdata; second_rm <= 1'b1;
          end else if (divr >= 12'(run_k)) begin
            divr <= divr - 12'(run_k); divq <= divq + 1'b1;
          end else begin
            vb <= vq_sat; second_rm <= 1'b0;
            state <= S_ADJ;
          end
        end
        S_ADJ: state <= S_CHK;
        S_CHK: begin
          if (!hold_close) begin
            row_a <= a_rdata;
            if (pt == 12'd1) begin
              // Second pass only fetches row b for the mirrored bit.
              state <= S_SETB;
            end else begin
              vertex_a <= 8'(va); vertex_b <= 8'(vb);
              if (va == vb || a_rdata[vb]) begin
                status <= closing ? rrgp_pkg::ST_FINAL_FAIL
                          : ((va == vb) ? rrgp_pkg::ST_SAME : rrgp_pkg::ST_EXISTS);
                remaining <= rem; last <= 1'b1;
                if (closing) running <= 1'b0;
                state <= closing ? S_WAIT : S_IDLE;
              end else begin
                pt <= 12'd0;
                state <= S_SETB;
              end
            end
          end
        end
        S_SETB: begin
          // first pass writes row a, second pass row b
          if (!hold_close) begin
            if (pt == 12'd0) begin
              row_a <= '0; pt <= 12'd1;
              {va, vb} <= {vb, va};
              state <= S_ADJ;
            end else begin
              {va, vb} <= {vb, va};
              if (closing) begin
                status <= rrgp_pkg::ST_FINAL_OK; remaining <= '0; last <= 1'b1;
                rem <= '0; running <= 1'b0;
                state <= S_WAIT;
              end else begin
                cnt <= (p1 > p2) ? p1[PW-1:0] : p2[PW-1:0];
                second_rm <= 1'b0;
                state <= S_SHRD;
              end
            end
          end
        end
        S_SHRD: begin
          if (12'(cnt) + 12'd1 >= rem) begin
            rem <= rem - 12'd1;
            if (!second_rm) begin
              second_rm <= 1'b1;
              cnt <= (p1 > p2) ? p2[PW-1:0] : p1[PW-1:0];
            end else begin
              second_rm <= 1'b0;
              state <= S_OUT;
            end
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          cnt <= PW'(cnt + 1'b1);
          state <= S_SHRD;
        end
        S_OUT: begin
          if (!out_valid) begin
            status <= rrgp_pkg::ST_ADDED; remaining <= rem;
            last <= (rem > 12'd2) ? 1'b1 : 1'b0;
            if (rem > 12'd2) begin
              state <= S_IDLE;
            end else begin
              closing <= 1'b1;
              p1 <= 12'd0; p2 <= 12'd1;
              state <= S_RD1;
            end
          end
        end
        S_CLOSE: state <= S_IDLE;
        S_WAIT: begin
          // hold the closing result before new requests
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_busy_no_accept;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> !in_ready;
  endproperty
  assert property (p_busy_no_accept) else $error("request taken while busy");

  property p_rem_bound;
    @(posedge clk) disable iff (rst) running |-> (rem <= 12'(CAP));
  endproperty
  assert property (p_rem_bound) else $error("remaining above capacity");

  property p_last_zero_added;
    @(posedge clk) disable iff (rst) (out_valid && !last) |-> (status == rrgp_pkg::ST_ADDED);
  endproperty
  assert property (p_last_zero_added) else $error("non-last result not an add");
endmodule
`default_nettype wire
